// ===== sv/lpht_pkg.sv =====
`default_nettype none
package lpht_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int SIZE_W  = 11;
	localparam int COUNT_W = 11;
	localparam int MULT_W  = 9;
	localparam int WORD_W  = 1 + KEY_W + VAL_W;   // {used, key, value}

	localparam logic [MULT_W-1:0] HASH_MULT  = 9'd433;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd17;
	localparam logic [VAL_W-1:0]  MISS_VALUE = '1;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic hash;
		logic seed;
		logic probe;
		logic resp;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic probe_fin;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/lpht_if.sv =====
`default_nettype none
interface lpht_req_if;
	import lpht_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [KEY_W-1:0]  key;
	logic [VAL_W-1:0]  value;

	modport source (output valid, req_type, key, value, input ready);
	modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lpht_rsp_if;
	import lpht_pkg::*;
	logic               valid;
	logic               ready;
	status_t            status;
	logic [VAL_W-1:0]   value_out;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, status, value_out, entry_count, input ready);
	modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface

interface lpht_cfg_if;
	import lpht_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] table_size;

	modport source (output valid, table_size, input ready);
	modport sink   (input valid, table_size, output ready);
endinterface
`default_nettype wire

// ===== sv/linear_probe_hash_table_core.sv =====
`default_nettype none
// Open-addressing key/value table with linear probing.
// Channels (valid/ready, a beat moves when both are high):
//   req : req_type (0 insert, 1 lookup), key, value.
//   rsp : status (done/found, not found, full), value_out, entry_count.
//   cfg : table_size, always ready; write only while no request is in flight.
// Home slot is (key*433 mod 2^32) mod n, n = table_size clamped to 1..MAX_SLOTS.
// Per request: hash multiply, remainder (4 bits a cycle), issue of the first
// slot read, then k slots examined (one table memory read per cycle,
// registered read data). k is 1 for an insert into an empty home slot and
// at most n for a miss or a full table. No new request is taken until the
// previous result has been loaded into the output register.
// Reset: table_size returns to 17, count to zero, and the slot memory is
// swept clear, one slot a cycle, all MAX_SLOTS slots before req.ready rises.
// Stall: the response sits in an output register; while rsp.ready is low a
// new request is still taken, and its result waits until that beat is gone.
module linear_probe_hash_table_core #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lpht_req_if.sink  req,
	lpht_rsp_if.source rsp,
	lpht_cfg_if.sink  cfg
);
	import lpht_pkg::*;

	cmd_t cmd;   // controller commands
	sts_t sts;   // datapath status

	// config register is always writable
	assign cfg.ready = 1'b1;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpht_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg.valid),
		.cfg_size   (cfg.table_size),
		.req_type   (req.req_type),
		.key        (req.key),
		.value      (req.value),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_value  (rsp.value_out),
		.rsp_count  (rsp.entry_count)
	);

endmodule
`default_nettype wire

// ===== sv/lpht_ram.sv =====
`default_nettype none
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/lpht_mod.sv =====
`default_nettype none
// Iterative remainder: dividend mod divisor, four restoring steps per cycle.
module lpht_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lpht_pkg::KEY_W-1:0]  dividend,
	input  wire logic [lpht_pkg::SIZE_W-1:0] divisor,
	output logic                             last,
	output logic      [lpht_pkg::SIZE_W-1:0] rem
);
	import lpht_pkg::*;

	localparam int STEPS  = 4;
	localparam int CYCLES = KEY_W / STEPS;
	localparam int CNT_W  = $clog2(CYCLES);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0] rem_q;
	logic [KEY_W-1:0]  dvd_q;

	logic [SIZE_W-1:0] r;
	logic [KEY_W-1:0]  sh;
	logic [SIZE_W:0]   t;

	always_comb begin
		r  = rem_q;
		sh = dvd_q;
		t  = '0;
		for (int i = 0; i < STEPS; i++) begin
			t  = {r, sh[KEY_W-1]};
			sh = {sh[KEY_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= r;
			dvd_q <= sh;
		end
	end

	assign last = busy_q && (cnt_q == CNT_W'(CYCLES - 1));
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== sv/lpht_dp.sv =====
`default_nettype none
module lpht_dp #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lpht_pkg::cmd_t               cmd,
	output lpht_pkg::sts_t                    sts,
	input  wire logic                         cfg_we,
	input  wire logic [lpht_pkg::SIZE_W-1:0]  cfg_size,
	input  wire logic                         req_type,
	input  wire logic [lpht_pkg::KEY_W-1:0]   key,
	input  wire logic [lpht_pkg::VAL_W-1:0]   value,
	input  wire logic                         rsp_ready,
	output logic                              rsp_valid,
	output lpht_pkg::status_t                 rsp_status,
	output logic      [lpht_pkg::VAL_W-1:0]   rsp_value,
	output logic      [lpht_pkg::COUNT_W-1:0] rsp_count
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CW    = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;

	// config and request
	logic [SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]  n;
	logic               lookup_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;

	// hash
	logic [KEY_W+MULT_W-1:0] prod;
	logic [SIZE_W-1:0]       rem;
	logic                    div_last;

	// probe
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   pos_q;
	logic [SIZE_W-1:0]  issued_q;
	logic               chk_v_s1;
	logic [IDX_W-1:0]   chk_pos_s1;
	logic               chk_last_s1;
	logic [COUNT_W-1:0] count_q;
	logic [CW-1:0]      rem_cw;
	logic [IDX_W-1:0]   base_pos;
	logic [SIZE_W-1:0]  base_iss;
	logic [CW-1:0]      pos_inc;
	logic [IDX_W-1:0]   pos_next;
	logic               issue;
	logic               hit;
	logic               fin;
	logic               ins_we;

	// table memory
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic               rd_used;
	logic [KEY_W-1:0]   rd_key;
	logic [VAL_W-1:0]   rd_val;

	// result
	status_t            res_status_q;
	logic [VAL_W-1:0]   res_value_q;
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [VAL_W-1:0]   rsp_value_q;
	logic [COUNT_W-1:0] rsp_count_q;

	// zero acts as one, oversize clamps to the table depth
	always_comb begin
		priority if (size_q == '0) begin
			n = SIZE_W'(1);
		end else if (size_q > MAX_SLOTS) begin
			n = SIZE_W'(MAX_SLOTS);
		end else begin
			n = size_q;
		end
	end

	assign prod = key_q * HASH_MULT;

	lpht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.hash),
		.dividend (prod[KEY_W-1:0]),
		.divisor  (n),
		.last     (div_last),
		.rem      (rem)
	);

	assign rd_used = ram_rdata[WORD_W-1];
	assign rd_key  = ram_rdata[VAL_W +: KEY_W];
	assign rd_val  = ram_rdata[VAL_W-1:0];

	assign rem_cw   = CW'(rem);
	assign base_pos = cmd.seed ? rem_cw[IDX_W-1:0] : pos_q;
	assign base_iss = cmd.seed ? '0 : issued_q;
	assign pos_inc  = CW'(base_pos) + CW'(1);
	assign pos_next = (pos_inc == CW'(n)) ? '0 : pos_inc[IDX_W-1:0];

	// insert wants an empty slot, lookup a used slot with the same key
	assign hit    = lookup_q ? (rd_used && (rd_key == key_q)) : !rd_used;
	assign fin    = cmd.probe && chk_v_s1 && (hit || chk_last_s1);
	assign ins_we = fin && !lookup_q && hit;
	assign issue  = cmd.seed || (cmd.probe && !fin && (issued_q != n));

	assign ram_we    = cmd.clr || ins_we;
	assign ram_waddr = cmd.clr ? clr_q : chk_pos_s1;
	assign ram_wdata = cmd.clr ? '0 : {1'b1, key_q, val_q};

	lpht_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (base_pos),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_RESET;
			clr_q       <= '0;
			chk_v_s1    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_size;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			chk_v_s1 <= issue;
			// count holds at all ones once it gets there
			if (ins_we && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.resp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lookup_q <= req_type;
			key_q    <= key;
			val_q    <= value;
		end
		if (issue) begin
			pos_q       <= pos_next;
			issued_q    <= base_iss + 1'b1;
			chk_pos_s1  <= base_pos;
			chk_last_s1 <= (base_iss == n - 1'b1);
		end
		if (fin) begin
			if (lookup_q) begin
				res_status_q <= hit ? ST_DONE : ST_MISS;
				res_value_q  <= hit ? rd_val : MISS_VALUE;
			end else begin
				res_status_q <= hit ? ST_DONE : ST_FULL;
				res_value_q  <= '0;
			end
		end
		if (cmd.resp) begin
			rsp_status_q <= res_status_q;
			rsp_value_q  <= res_value_q;
			rsp_count_q  <= count_q;
		end
	end

	assign sts.clr_last  = (clr_q == IDX_W'(MAX_SLOTS - 1));
	assign sts.div_last  = div_last;
	assign sts.probe_fin = fin;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = rsp_status_q;
	assign rsp_value  = rsp_value_q;
	assign rsp_count  = rsp_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_SLOTS)
		else $error("entry count above table depth");

	a_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && issue && (ram_waddr == base_pos)))
		else $error("table read and write hit the same slot");

	a_resp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp |-> (!rsp_valid_q || rsp_ready))
		else $error("result loaded over an untaken beat");
`endif

endmodule
`default_nettype wire

// ===== sv/lpht_ctrl.sv =====
`default_nettype none
module lpht_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire lpht_pkg::sts_t sts,
	output lpht_pkg::cmd_t      cmd
);
	import lpht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_DIV,
		S_SEED,
		S_PROBE,
		S_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) state_q <= S_HASH;
				end
				S_HASH: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) state_q <= S_SEED;
				end
				S_SEED: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (sts.probe_fin) state_q <= S_RESP;
				end
				S_RESP: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.clr   = (state_q == S_CLEAR);
		cmd.load  = (state_q == S_IDLE) && req_valid;
		cmd.hash  = (state_q == S_HASH);
		cmd.seed  = (state_q == S_SEED);
		cmd.probe = (state_q == S_PROBE);
		cmd.resp  = (state_q == S_RESP) && sts.out_free;
	end

	assign req_ready = (state_q == S_IDLE);

`ifndef SYNTH
	a_fin_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		sts.probe_fin |-> (state_q == S_PROBE))
		else $error("probe finish outside probe phase");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_last |-> (state_q == S_DIV))
		else $error("remainder unit running outside divide phase");
`endif

endmodule
`default_nettype wire

// ===== verif/linear_probe_hash_table_core_test.sv =====
`timescale 1ns / 100ps

module linear_probe_hash_table_core_test;
	import lpht_pkg::*;

	localparam int MAX_SLOTS = 1024;
	localparam int COUNT_CEIL = 2047;
	// The limit leaves a wide margin on top of the worst case, in which every
	// beat is a full 1024-slot scan plus the longest gap and stall.
	localparam int CYCLE_LIMIT = 5_000_000;
	// Longest request-to-response time: hashing plus a full scan.
	localparam int DRAIN_CYCLES = 1100;
	localparam int POOL_DEPTH = 200;

	typedef enum bit {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t          kind;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} table_req_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   value_out;
		logic [COUNT_W-1:0] entry_count;
	} table_answer_t;

	logic clk;
	logic arst_n;

	lpht_req_if req_ch ();
	lpht_rsp_if rsp_ch ();
	lpht_cfg_if cfg_ch ();

	linear_probe_hash_table_core #(
		.MAX_SLOTS(MAX_SLOTS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// ------------------------------------------------------------------
	// Mirror of the slot store, the size register and the entry count.
	// Updated at the edge where a request beat is taken, so it always
	// sees requests in the order the block does.
	// ------------------------------------------------------------------
	bit                 mirror_used [MAX_SLOTS];
	logic [KEY_W-1:0]   mirror_key  [MAX_SLOTS];
	logic [VAL_W-1:0]   mirror_val  [MAX_SLOTS];
	int unsigned        mirror_count;
	logic [SIZE_W-1:0]  mirror_size;

	table_req_t    req_backlog[$];       // requests not yet driven
	table_answer_t expected_answers[$];  // predicted responses, oldest first
	logic [KEY_W-1:0] key_pool[$];       // keys handed to inserts, for hits

	int  req_pushed;
	int  rsp_seen;
	int  fail_count;
	int  cycle_count;
	bit  req_beat;      // a request beat moved at the last rising edge
	bit  tx_idle_on;    // sender inserts gaps
	bit  rx_idle_on;    // receiver stalls
	int  send_gap;
	int  stall_left;

	// Sizes for the soak phases. Small tables dominate; the large ones
	// are slow on misses, so they get fewer requests than the mid sizes.
	int phase_size [12] = '{5, 1, 8, 31, 64, 130, 257, 3, 512, 1024, 2047, 700};
	int phase_len  [12] = '{80, 30, 100, 150, 150, 150, 150, 40, 120, 100, 60, 100};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predict one request against the mirror and apply its side effects.
	// Size 0 behaves as 1 and anything past MAX_SLOTS as MAX_SLOTS.
	function automatic table_answer_t probe_table(table_req_t r);
		table_answer_t ans;
		int unsigned   n;
		int unsigned   pos;
		int unsigned   steps;
		logic [31:0]   h;
		bit            hit;
		n = (mirror_size == 0) ? 1 :
			((mirror_size > MAX_SLOTS) ? MAX_SLOTS : int'(mirror_size));
		h = r.key * HASH_MULT;   // wraps at 2^32
		pos = h % n;
		steps = 0;
		hit = 1'b0;
		if (r.kind == REQ_LOOKUP) begin
			ans.status = ST_MISS;
			ans.value_out = MISS_VALUE;
			// slots are visited until a match or all n are seen; empties are passed over
			while (!hit && steps < n) begin
				if (mirror_used[pos] && mirror_key[pos] == r.key) begin
					hit = 1'b1;
					ans.status = ST_DONE;
					ans.value_out = mirror_val[pos];
				end else begin
					pos = (pos + 1 == n) ? 0 : pos + 1;
					steps++;
				end
			end
		end else begin
			ans.status = ST_FULL;
			ans.value_out = '0;
			// first empty slot wins, duplicates are stored again
			while (!hit && steps < n) begin
				if (!mirror_used[pos]) begin
					hit = 1'b1;
					mirror_used[pos] = 1'b1;
					mirror_key[pos] = r.key;
					mirror_val[pos] = r.value;
					mirror_count++;
					ans.status = ST_DONE;
				end else begin
					pos = (pos + 1 == n) ? 0 : pos + 1;
					steps++;
				end
			end
		end
		ans.entry_count = (mirror_count > COUNT_CEIL) ? COUNT_W'(COUNT_CEIL) :
			COUNT_W'(mirror_count);
		return ans;
	endfunction

	// Idle length: mostly none, some short, a few long.
	function automatic int pick_pause(bit enable);
		int r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 50);
	endfunction

	// Keys come from earlier inserts (for hits and duplicates) or are fresh:
	// full-range, tiny, or high-byte-only so home slots cluster.
	function automatic logic [KEY_W-1:0] pick_key(int pool_pct);
		if (key_pool.size() > 0 && $urandom_range(0, 99) < pool_pct)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return KEY_W'($urandom_range(0, 63));
			default: return {8'($urandom_range(0, 255)), 24'h0};
		endcase
	endfunction

	task automatic queue_req(req_kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		table_req_t r;
		r.kind = kind;
		r.key = key;
		r.value = value;
		req_backlog.push_back(r);
		req_pushed++;
	endtask

	task automatic queue_random_req(int lookup_pct, int hit_pct);
		logic [KEY_W-1:0] k;
		if ($urandom_range(0, 99) < lookup_pct) begin
			queue_req(REQ_LOOKUP, pick_key(hit_pct), $urandom);
		end else begin
			k = pick_key(15);
			queue_req(REQ_INSERT, k, $urandom);
			key_pool.push_back(k);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
		end
	endtask

	// Block until every request handed over has been answered.
	task automatic wait_drained();
		while (rsp_seen != req_pushed)
			@(posedge clk);
	endtask

	// Size writes happen only with nothing in flight.
	task automatic write_table_size(logic [SIZE_W-1:0] sz);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.table_size <= sz;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Request driver: changes at the falling edge, holds a beat until it
	// is taken, then waits a random gap before the next one.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		table_req_t item;
		if (req_ch.valid && !req_beat) begin
			// beat still waiting for ready
		end else if (send_gap > 0) begin
			send_gap--;
			req_ch.valid <= 1'b0;
		end else if (req_backlog.size() > 0) begin
			item = req_backlog.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.req_type <= item.kind;
			req_ch.key <= item.key;
			req_ch.value <= item.value;
			send_gap = pick_pause(tx_idle_on);
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// Response backpressure: ready drops for random stretches.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			stall_left = pick_pause(rx_idle_on);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: samples every channel at the rising edge. A taken request
	// is predicted right away; a taken response is checked against the
	// oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		table_req_t    seen_req;
		table_answer_t want;
		req_beat <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				mirror_size = cfg_ch.table_size;
			if (req_ch.valid && req_ch.ready) begin
				seen_req.kind = req_kind_t'(req_ch.req_type);
				seen_req.key = req_ch.key;
				seen_req.value = req_ch.value;
				expected_answers.push_back(probe_table(seen_req));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_seen++;
				if (expected_answers.size() == 0) begin
					$error("response beat with no request outstanding");
					fail_count++;
				end else begin
					want = expected_answers.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.value_out !== want.value_out) begin
						$error("value_out: expected %h, got %h",
							want.value_out, rsp_ch.value_out);
						fail_count++;
					end
					if (rsp_ch.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp_ch.entry_count);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus: directed corners first, then soak phases over a range of
	// table sizes. The store is never cleared after reset, so sizes are
	// ordered to leave room for inserts in most phases.
	// ------------------------------------------------------------------
	initial begin
		int lookup_pct;
		int hit_pct;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.table_size = '0;
		mirror_size = SIZE_RESET;
		mirror_count = 0;
		foreach (mirror_used[i])
			mirror_used[i] = 1'b0;
		req_pushed = 0;
		rsp_seen = 0;
		fail_count = 0;
		cycle_count = 0;
		req_beat = 1'b0;
		send_gap = 0;
		stall_left = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size: all-zero and all-one keys and values, a miss,
		// a duplicate key (first copy must win)
		write_table_size(SIZE_RESET);
		queue_req(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(REQ_LOOKUP, 32'h0000_3039, 32'h0000_0000);
		queue_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0001);
		queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		queue_req(REQ_INSERT, 32'hAAAA_5555, 32'h5555_AAAA);
		queue_req(REQ_LOOKUP, 32'hAAAA_5555, 32'hFFFF_FFFF);

		// shrink below the occupied range: probe wrap, then full table
		write_table_size(11'd3);
		queue_req(REQ_INSERT, 32'h0000_0001, 32'h1111_1111);
		queue_req(REQ_INSERT, 32'h0000_0002, 32'h2222_2222);
		queue_req(REQ_INSERT, 32'h0000_0003, 32'h3333_3333);
		queue_req(REQ_INSERT, 32'h0000_0004, 32'h4444_4444);
		queue_req(REQ_LOOKUP, 32'h0000_0004, 32'h0000_0000);
		queue_req(REQ_LOOKUP, 32'h0000_0063, 32'h0000_0000);

		// zero size acts as one slot
		write_table_size(11'd0);
		queue_req(REQ_INSERT, 32'h0000_0007, 32'h7777_7777);
		queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);

		// all-ones size clamps to the full store
		write_table_size(11'h7FF);
		queue_req(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_req(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

		write_table_size(11'(MAX_SLOTS));
		queue_req(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		queue_req(REQ_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000);

		write_table_size(11'd1);
		queue_req(REQ_INSERT, 32'h0000_0005, 32'h5555_5555);

		// soak phases; each size write waits for a full drain first
		foreach (phase_size[p]) begin
			write_table_size(SIZE_W'(phase_size[p]));
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			// big tables: mostly known keys, a miss costs a full scan
			lookup_pct = (phase_size[p] >= 500) ? 50 : 40;
			hit_pct = (phase_size[p] >= 500) ? 90 : 60;
			for (int i = 0; i < phase_len[p]; i++) begin
				queue_random_req(lookup_pct, hit_pct);
				// now and then the sender stops until everything is back
				if ($urandom_range(0, 79) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_answers.size() != 0) begin
			$error("%0d responses never arrived", expected_answers.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
